// File: rtl/core/hrld_pkg.sv
// ----------------------------------------------------------------------------
// hrld_pkg
// shared types, codes and constants of the http response length deframer
// ----------------------------------------------------------------------------
package hrld_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 30;
  localparam int unsigned HDR_CNT_W  = 16;
  localparam int unsigned TAIL_W     = 24;
  localparam int unsigned KEY_LEN    = 16;
  localparam int unsigned KEY_IDX_W  = 5;
  localparam int unsigned MAX_DIGITS = 9;
  localparam logic [HDR_CNT_W-1:0] MAX_HDR_RESET = 16'd8192;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [TAIL_W-1:0] TAIL_CRLFCR = {CH_CR, CH_LF, CH_CR};

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    NP_SEEK_KEY    = 2'd0,
    NP_SEEK_DIGITS = 2'd1,
    NP_IN_DIGITS   = 2'd2,
    NP_RUN_ENDED   = 2'd3
  } num_phase_e;

  typedef enum logic [1:0] {
    CLS_HEADER  = 2'd0,
    CLS_BODY    = 2'd1,
    CLS_IGNORED = 2'd2
  } byte_class_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HDR_LONG = 2'd1,
    ST_NO_CLEN  = 2'd2,
    ST_LEN_LONG = 2'd3
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    byte_class_e       byte_class;
    logic              header_end;
    logic              body_last;
    logic [LEN_W-1:0]  content_length;
    status_e           status;
  } result_t;

  // "Content-Length: "
  function automatic logic [BYTE_W-1:0] key_char(input logic [3:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3a;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/hrld_parser.sv
// ----------------------------------------------------------------------------
// hrld_parser
// parse state of one response and the per-byte classification step
// ----------------------------------------------------------------------------
module hrld_parser #(
  parameter int unsigned MaxDigits = hrld_pkg::MAX_DIGITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [hrld_pkg::BYTE_W-1:0]         byte_i,
  input  logic                                new_i,
  input  logic [hrld_pkg::HDR_CNT_W-1:0]      max_hdr_i,
  output hrld_pkg::result_t                   res_o
);

  localparam int unsigned DcW   = $clog2(MaxDigits + 2);
  localparam int unsigned LenW  = hrld_pkg::LEN_W;
  localparam int unsigned CntW  = hrld_pkg::HDR_CNT_W;
  localparam int unsigned TailW = hrld_pkg::TAIL_W;
  localparam int unsigned KiW   = hrld_pkg::KEY_IDX_W;

  hrld_pkg::phase_e       phase_q, phase_d, phase_e_w;
  hrld_pkg::num_phase_e   np_q, np_d, np_e_w, np_s;
  hrld_pkg::status_e      err_q, err_d, err_e_w;
  logic [CntW-1:0]        cnt_q, cnt_d, cnt_e_w;
  logic [TailW-1:0]       tail_q, tail_d, tail_e_w;
  logic [KiW-1:0]         kmi_q, kmi_d, kmi_e_w, kmi_s;
  logic [DcW-1:0]         dc_q, dc_d, dc_e_w, dc_s;
  logic [LenW-1:0]        lv_q, lv_d, lv_e_w, lv_s;
  logic [LenW-1:0]        rem_q, rem_d, rem_e_w, rem_dec;
  logic [CntW:0]          cnt_next;
  logic                   hdr_ok, term_hit, is_digit, len_long;
  logic [LenW-1:0]        digit_val;

  // new_response clears parse state ahead of the byte
  always_comb begin
    if (new_i) begin
      phase_e_w = hrld_pkg::PH_HEADER;
      np_e_w    = hrld_pkg::NP_SEEK_KEY;
      err_e_w   = hrld_pkg::ST_OK;
      cnt_e_w   = '0;
      tail_e_w  = '0;
      kmi_e_w   = '0;
      dc_e_w    = '0;
      lv_e_w    = '0;
      rem_e_w   = '0;
    end else begin
      phase_e_w = phase_q;
      np_e_w    = np_q;
      err_e_w   = err_q;
      cnt_e_w   = cnt_q;
      tail_e_w  = tail_q;
      kmi_e_w   = kmi_q;
      dc_e_w    = dc_q;
      lv_e_w    = lv_q;
      rem_e_w   = rem_q;
    end
  end

  assign cnt_next  = {1'b0, cnt_e_w} + {{CntW{1'b0}}, 1'b1};
  assign hdr_ok    = cnt_next <= {1'b0, max_hdr_i};
  assign term_hit  = (tail_e_w == hrld_pkg::TAIL_CRLFCR) && (byte_i == hrld_pkg::CH_LF);
  assign is_digit  = (byte_i >= hrld_pkg::CH_ZERO) && (byte_i <= hrld_pkg::CH_NINE);
  assign digit_val = {{(LenW-hrld_pkg::BYTE_W){1'b0}}, byte_i - hrld_pkg::CH_ZERO};
  assign rem_dec   = (rem_e_w != '0) ? rem_e_w - {{(LenW-1){1'b0}}, 1'b1} : rem_e_w;
  assign len_long  = dc_s > DcW'(MaxDigits);

  // keyword match and digit accumulation
  always_comb begin
    np_s  = np_e_w;
    kmi_s = kmi_e_w;
    dc_s  = dc_e_w;
    lv_s  = lv_e_w;
    case (np_e_w)
      hrld_pkg::NP_SEEK_KEY: begin
        if ((kmi_e_w < KiW'(hrld_pkg::KEY_LEN)) &&
            (byte_i == hrld_pkg::key_char(kmi_e_w[3:0]))) begin
          kmi_s = kmi_e_w + {{(KiW-1){1'b0}}, 1'b1};
          if (kmi_s == KiW'(hrld_pkg::KEY_LEN)) begin
            np_s = hrld_pkg::NP_SEEK_DIGITS;
          end
        end else begin
          kmi_s = (byte_i == hrld_pkg::key_char(4'd0)) ? KiW'(1) : '0;
        end
      end
      hrld_pkg::NP_SEEK_DIGITS, hrld_pkg::NP_IN_DIGITS: begin
        if (is_digit) begin
          np_s = hrld_pkg::NP_IN_DIGITS;
          if (dc_e_w < DcW'(MaxDigits)) begin
            lv_s = (lv_e_w << 3) + (lv_e_w << 1) + digit_val;
            dc_s = dc_e_w + {{(DcW-1){1'b0}}, 1'b1};
          end else begin
            dc_s = DcW'(MaxDigits + 1);
            np_s = hrld_pkg::NP_RUN_ENDED;
          end
        end else if (np_e_w == hrld_pkg::NP_IN_DIGITS) begin
          np_s = hrld_pkg::NP_RUN_ENDED;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_e_w;
    np_d    = np_e_w;
    err_d   = err_e_w;
    cnt_d   = cnt_e_w;
    tail_d  = tail_e_w;
    kmi_d   = kmi_e_w;
    dc_d    = dc_e_w;
    lv_d    = lv_e_w;
    rem_d   = rem_e_w;
    unique case (phase_e_w)
      hrld_pkg::PH_HEADER: begin
        if (!hdr_ok) begin
          phase_d = hrld_pkg::PH_ERROR;
          err_d   = hrld_pkg::ST_HDR_LONG;
        end else begin
          cnt_d  = cnt_next[CntW-1:0];
          np_d   = np_s;
          kmi_d  = kmi_s;
          dc_d   = dc_s;
          lv_d   = lv_s;
          tail_d = {tail_e_w[TailW-9:0], byte_i};
          if (term_hit) begin
            if (np_s == hrld_pkg::NP_SEEK_KEY) begin
              phase_d = hrld_pkg::PH_ERROR;
              err_d   = hrld_pkg::ST_NO_CLEN;
            end else if (len_long) begin
              phase_d = hrld_pkg::PH_ERROR;
              err_d   = hrld_pkg::ST_LEN_LONG;
            end else if (lv_s == '0) begin
              phase_d = hrld_pkg::PH_DONE;
            end else begin
              rem_d   = lv_s;
              phase_d = hrld_pkg::PH_BODY;
            end
          end
        end
      end
      hrld_pkg::PH_BODY: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d = hrld_pkg::PH_DONE;
        end
      end
      hrld_pkg::PH_DONE, hrld_pkg::PH_ERROR: ;
      default: ;
    endcase
  end

  // result of this byte
  always_comb begin
    res_o                = '0;
    res_o.out_byte       = byte_i;
    res_o.byte_class     = hrld_pkg::CLS_IGNORED;
    res_o.status         = hrld_pkg::ST_OK;
    unique case (phase_e_w)
      hrld_pkg::PH_HEADER: begin
        if (!hdr_ok) begin
          res_o.status = hrld_pkg::ST_HDR_LONG;
        end else begin
          res_o.byte_class = hrld_pkg::CLS_HEADER;
          if (term_hit) begin
            res_o.header_end = 1'b1;
            if (np_s == hrld_pkg::NP_SEEK_KEY) begin
              res_o.status = hrld_pkg::ST_NO_CLEN;
            end else if (len_long) begin
              res_o.status = hrld_pkg::ST_LEN_LONG;
            end else begin
              res_o.content_length = lv_s;
              res_o.body_last      = (lv_s == '0);
            end
          end
        end
      end
      hrld_pkg::PH_BODY: begin
        res_o.byte_class = hrld_pkg::CLS_BODY;
        res_o.body_last  = (rem_dec == '0);
      end
      hrld_pkg::PH_ERROR: begin
        res_o.status = err_e_w;
      end
      hrld_pkg::PH_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrld_pkg::PH_HEADER;
      np_q    <= hrld_pkg::NP_SEEK_KEY;
      err_q   <= hrld_pkg::ST_OK;
      cnt_q   <= '0;
      tail_q  <= '0;
      kmi_q   <= '0;
      dc_q    <= '0;
      lv_q    <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      np_q    <= np_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
      tail_q  <= tail_d;
      kmi_q   <= kmi_d;
      dc_q    <= dc_d;
      lv_q    <= lv_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// File: rtl/core/http_response_length_deframer_core.sv
// ----------------------------------------------------------------------------
// http_response_length_deframer_core
// splits an http response byte stream into header and content-length body
// ----------------------------------------------------------------------------
// One byte is taken per clock while the output side accepts, and every byte
// gives one result transfer; each byte is held in the input register and
// its result in the output register. The combinational parse step between
// them sets the rate; the two stall together only while the output holds off.
// Bytes up to the first CRLFCRLF are tagged header (terminator included,
// header_end on its last byte), then content_length bytes are tagged body
// with tlast on the final one; later bytes and bytes after an error are
// tagged ignored. Write max_header_bytes only while no byte is in flight.
module http_response_length_deframer_core #(
  parameter int unsigned MaxDigits = hrld_pkg::MAX_DIGITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // max_header_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // new_response
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte, content_length, status
  output logic [2:0]  m_axis_tuser,   // byte_class, header_end
  output logic        m_axis_tlast    // body_last
);

  logic                                 in_valid_q;
  logic [hrld_pkg::BYTE_W-1:0]          in_byte_q;
  logic                                 in_new_q;
  logic                                 out_valid_q;
  hrld_pkg::result_t                    out_res_q;
  hrld_pkg::result_t                    res;
  logic [hrld_pkg::HDR_CNT_W-1:0]       max_hdr_q;
  logic                                 advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  hrld_parser #(
    .MaxDigits (MaxDigits)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .new_i     (in_new_q),
    .max_hdr_i (max_hdr_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_hdr_q <= hrld_pkg::MAX_HDR_RESET;
    end else if (cfg_we_i) begin
      max_hdr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_new_q  <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.status, out_res_q.content_length, out_res_q.out_byte};
  assign m_axis_tuser  = {out_res_q.header_end, out_res_q.byte_class};
  assign m_axis_tlast  = out_res_q.body_last;

  a_hend_is_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res_q.header_end |-> out_res_q.byte_class == hrld_pkg::CLS_HEADER)
    else $error("header_end on a byte not tagged header");

  a_last_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> out_res_q.status == hrld_pkg::ST_OK)
    else $error("body_last together with an error status");

  a_clen_only_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_res_q.header_end |-> out_res_q.content_length == '0)
    else $error("content_length set away from header_end");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("parsed byte did not reach the output register");

endmodule

// File: verif/http_response_length_deframer_core_test.sv
// ----------------------------------------------------------------------------
// http_response_length_deframer_core_test
// Self-checking bench for the http response length deframer. Generates HTTP
// responses, mostly well formed, and mixes in noise and cut responses. It
// runs them through the stream ports under several header size limits,
// predicts every result transfer, and compares each field in order.
// ----------------------------------------------------------------------------
module http_response_length_deframer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [127:0] CLEN_KEY = "Content-Length: ";
  localparam logic [127:0] FILLER_CHARS = "Cont-Lgh: 0159xZ";

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  http_response_length_deframer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  class deframe_scoreboard;
    logic [15:0]          hdr_limit;
    hrld_pkg::phase_e     ph;
    logic [15:0]          hdr_cnt;
    logic [23:0]          tail;
    int unsigned          key_idx;
    hrld_pkg::num_phase_e nph;
    int unsigned          digits;
    logic [29:0]          len_acc;
    logic [29:0]          body_left;
    hrld_pkg::status_e    err;
    hrld_pkg::result_t    due_results[$];
    int                   errors;

    function new();
      hdr_limit = hrld_pkg::MAX_HDR_RESET;
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      ph = hrld_pkg::PH_HEADER;
      hdr_cnt = '0;
      tail = '0;
      key_idx = 0;
      nph = hrld_pkg::NP_SEEK_KEY;
      digits = 0;
      len_acc = '0;
      body_left = '0;
      err = hrld_pkg::ST_OK;
    endfunction

    function void set_limit(logic [15:0] v);
      hdr_limit = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void scan_for_length(logic [7:0] b);
      logic is_digit;
      is_digit = (b >= hrld_pkg::CH_ZERO) && (b <= hrld_pkg::CH_NINE);
      case (nph)
        hrld_pkg::NP_SEEK_KEY: begin
          if (key_idx < hrld_pkg::KEY_LEN && b == CLEN_KEY[127 - 8*key_idx -: 8]) begin
            key_idx++;
            if (key_idx == hrld_pkg::KEY_LEN) nph = hrld_pkg::NP_SEEK_DIGITS;
          end else begin
            key_idx = (b == CLEN_KEY[127 -: 8]) ? 32'd1 : 32'd0;
          end
        end
        hrld_pkg::NP_SEEK_DIGITS, hrld_pkg::NP_IN_DIGITS: begin
          if (is_digit) begin
            nph = hrld_pkg::NP_IN_DIGITS;
            if (digits < hrld_pkg::MAX_DIGITS) begin
              len_acc = 30'(32'(len_acc) * 32'd10 + 32'(b - hrld_pkg::CH_ZERO));
              digits++;
            end else begin
              digits = hrld_pkg::MAX_DIGITS + 1;
              nph = hrld_pkg::NP_RUN_ENDED;
            end
          end else if (nph == hrld_pkg::NP_IN_DIGITS) begin
            nph = hrld_pkg::NP_RUN_ENDED;
          end
        end
        default: ;
      endcase
    endfunction

    // predict the result of one accepted byte
    function void classify_byte(logic [7:0] b, logic new_resp);
      hrld_pkg::result_t r;
      int unsigned       next_cnt;
      if (new_resp) clear_parse();
      r = '0;
      r.out_byte = b;
      r.byte_class = hrld_pkg::CLS_IGNORED;
      r.status = hrld_pkg::ST_OK;
      case (ph)
        hrld_pkg::PH_HEADER: begin
          next_cnt = 32'(hdr_cnt) + 32'd1;
          if (next_cnt > 32'(hdr_limit)) begin
            ph = hrld_pkg::PH_ERROR;
            err = hrld_pkg::ST_HDR_LONG;
            r.status = hrld_pkg::ST_HDR_LONG;
          end else begin
            hdr_cnt = next_cnt[15:0];
            r.byte_class = hrld_pkg::CLS_HEADER;
            scan_for_length(b);
            if (tail == hrld_pkg::TAIL_CRLFCR && b == hrld_pkg::CH_LF) begin
              r.header_end = 1'b1;
              if (nph == hrld_pkg::NP_SEEK_KEY) begin
                ph = hrld_pkg::PH_ERROR;
                err = hrld_pkg::ST_NO_CLEN;
                r.status = hrld_pkg::ST_NO_CLEN;
              end else if (digits > hrld_pkg::MAX_DIGITS) begin
                ph = hrld_pkg::PH_ERROR;
                err = hrld_pkg::ST_LEN_LONG;
                r.status = hrld_pkg::ST_LEN_LONG;
              end else begin
                r.content_length = len_acc;
                if (len_acc == '0) begin
                  r.body_last = 1'b1;
                  ph = hrld_pkg::PH_DONE;
                end else begin
                  body_left = len_acc;
                  ph = hrld_pkg::PH_BODY;
                end
              end
            end
            tail = {tail[15:0], b};
          end
        end
        hrld_pkg::PH_BODY: begin
          r.byte_class = hrld_pkg::CLS_BODY;
          if (body_left > '0) body_left--;
          if (body_left == '0) begin
            r.body_last = 1'b1;
            ph = hrld_pkg::PH_DONE;
          end
        end
        hrld_pkg::PH_ERROR: r.status = err;
        default: ;
      endcase
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t %s mismatch: expected 0x%0h actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [39:0] tdata, logic [2:0] tuser, logic tlast);
      hrld_pkg::result_t want;
      if (due_results.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual tdata 0x%0h tuser 0x%0h",
                 $time, tdata, tuser);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("out_byte", 32'(want.out_byte), 32'(tdata[7:0]));
      compare_field("content_length", 32'(want.content_length), 32'(tdata[37:8]));
      compare_field("status", 32'(want.status), 32'(tdata[39:38]));
      compare_field("byte_class", 32'(want.byte_class), 32'(tuser[1:0]));
      compare_field("header_end", 32'(want.header_end), 32'(tuser[2]));
      compare_field("body_last", 32'(want.body_last), 32'(tlast));
    endfunction
  endclass

  deframe_scoreboard sb = new();

  logic [8:0] stim_q[$];
  bit         fresh;
  bit         idle_on;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.classify_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold = int'($urandom_range(1, 12)) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t watchdog: no transfer for %0d cycles", $time, quiet);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic begin_response();
    fresh = 1'b1;
  endtask

  task automatic add_byte(input logic [7:0] b);
    stim_q.push_back({fresh, b});
    fresh = 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_crlf();
    add_byte(hrld_pkg::CH_CR);
    add_byte(hrld_pkg::CH_LF);
  endtask

  task automatic add_line(input string s);
    add_text(s);
    add_crlf();
  endtask

  task automatic add_filler();
    int n;
    n = $urandom_range(1, 6);
    add_text("Xy: ");
    repeat (n) add_byte(FILLER_CHARS[127 - 8*$urandom_range(0, 15) -: 8]);
    add_crlf();
  endtask

  task automatic gen_response();
    int          kind;
    int          body_len;
    int          start;
    int          cut;
    int unsigned big;
    logic [7:0]  nb;
    logic        nr;
    start = stim_q.size();
    body_len = 0;
    begin_response();
    if ($urandom_range(0, 2) == 0) add_line("HTTP/1.1 200 OK");
    repeat ($urandom_range(0, 2)) add_filler();
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        if ($urandom_range(0, 1) == 1) add_line("content-length: 5");
        body_len = $urandom_range(0, 3);
      end
      1: begin
        add_line("Content-Length: ");
        if ($urandom_range(0, 1) == 1) begin
          add_line("Age: 7");
          body_len = 7;
        end
      end
      2: begin
        add_line($sformatf("Content-Length: %0d%0d", $urandom_range(1, 9),
                           $urandom_range(100000000, 999999999)));
        body_len = $urandom_range(0, 3);
      end
      3: begin
        big = ($urandom_range(0, 3) == 0) ? 999999999 : $urandom_range(100000000, 999999999);
        add_line($sformatf("Content-Length: %0d", big));
        body_len = $urandom_range(1, 6);
      end
      4: add_line("Content-Length: 0");
      default: begin
        body_len = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0: add_line($sformatf("Content-Length: 00%0d", body_len));
          1: add_line($sformatf("Content-Length: %0d %0d", body_len, $urandom_range(0, 99)));
          default: add_line($sformatf("Content-Length: %0d", body_len));
        endcase
      end
    endcase
    repeat ($urandom_range(0, 1)) add_filler();
    add_crlf();
    repeat (body_len) add_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, stim_q.size() - start);
      while (stim_q.size() > start + cut) void'(stim_q.pop_back());
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        nb = 8'($urandom_range(0, 255));
        nr = ($urandom_range(0, 5) == 0);
        stim_q.push_back({nr, nb});
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic nr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= nr;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic play_stream();
    foreach (stim_q[i]) send_byte(stim_q[i][7:0], stim_q[i][8]);
    s_axis_tvalid <= 1'b0;
    stim_q.delete();
  endtask

  // only while no transfer is in flight
  task automatic write_hdr_limit(input logic [15:0] v);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(v);
  endtask

  initial begin
    logic [15:0] lim;
    int          budget;
    int          sent;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    idle_on       = 1'b1;
    fresh         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest limit: second header byte overflows, error sticks
    write_hdr_limit(16'd1);
    begin_response();
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(hrld_pkg::CH_CR);
    play_stream();

    // largest limit: one-byte body, then an ignored byte
    write_hdr_limit(16'hffff);
    begin_response();
    add_line("Content-Length: 1");
    add_crlf();
    add_byte(8'hff);
    add_byte(8'h00);
    play_stream();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: lim = hrld_pkg::MAX_HDR_RESET;
        1: lim = 16'd36;
        2: lim = 16'hffff;
        3: lim = 16'd1;
        default: lim = 16'($urandom_range(20, 80));
      endcase
      budget  = (p == 3) ? 20 : 75;
      idle_on = (p != 4);
      write_hdr_limit(lim);
      sent = 0;
      while (sent < budget) begin
        gen_response();
        sent += stim_q.size();
        play_stream();
      end
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: http_response_length_deframer_core.f
rtl/core/hrld_pkg.sv
rtl/core/hrld_parser.sv
rtl/core/http_response_length_deframer_core.sv
verif/http_response_length_deframer_core_test.sv
